/* hdl/skdc_pkg.sv */
// Shared types, constants and elaboration-time tables for the soft-knee compressor.
// Depends on nothing; every other file imports it.
package skdc_pkg;

	localparam int CHANNELS        = 2;
	localparam int LOG_TABLE_DEPTH = 256;
	localparam int EXP_TABLE_DEPTH = 256;

	localparam int SAMPLE_W  = 24;
	localparam int KEY_W     = 32;
	localparam int COEFF_W   = 24;
	localparam int GAIN_W    = 15;
	localparam int MAKEUP_W  = 16;
	localparam int GM_W      = 31;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int LOG_W     = 17;
	localparam int EXP_W     = 31;
	localparam int EXP_ROOTS = 20;
	localparam int LOG_IDX_W = $clog2(LOG_TABLE_DEPTH + 1);
	localparam int EXP_IDX_W = $clog2(EXP_TABLE_DEPTH + 1);

	localparam int QUOT_W = 14;
	localparam int NUM_W  = 46;
	localparam int DEN_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAKEUP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RMS_MODE  = 3'd6;

	localparam logic signed [17:0] LEVEL_FLOOR_DB  = -18'sd61440;
	localparam logic [18:0]        DB_PER_OCT_PEAK = 19'd394566;
	localparam logic [18:0]        DB_PER_OCT_RMS  = 19'd197283;
	localparam logic [21:0]        OCT_PER_DB      = 22'd2786635;

	typedef logic [LOG_W-1:0] log_tab_t [0:LOG_TABLE_DEPTH];
	typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_DEPTH];
	typedef logic [63:0] root_arr_t [0:EXP_ROOTS-1];

	// Per-lane controls issued by the sequencer.
	typedef struct packed {
		logic key_en;
		logic out_en;
		logic pwr;
	} lane_ctl_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bit_v;
		logic [63:0] xv;
		xv    = x;
		res   = 64'd0;
		bit_v = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (bit_v > xv) bit_v = bit_v >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (bit_v != 64'd0) begin
				if (xv >= res + bit_v) begin
					xv  = xv - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
		end
		return res;
	endfunction

	// log2(1 + i/D) in Q0.16 by repeated squaring.
	function automatic log_tab_t build_log_tab();
		log_tab_t    t;
		logic [63:0] y;
		logic [63:0] r;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
			r = 64'd0;
			for (int k = 0; k < 18; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r = r | 64'd1;
				end
			end
			t[i] = LOG_W'((r + 64'd2) >> 2);
		end
		return t;
	endfunction

	// 2^(-i/D) in Q1.30 from a product of repeated square roots of one half.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		root_arr_t   root;
		logic [63:0] x;
		logic [63:0] v;
		root[0] = isqrt64(64'd1 << 59);
		for (int k = 1; k < EXP_ROOTS; k++) root[k] = isqrt64(root[k-1] << 30);
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			x = ((64'(i) << EXP_ROOTS) + 64'(EXP_TABLE_DEPTH / 2)) / EXP_TABLE_DEPTH;
			v = ((x >> EXP_ROOTS) != 64'd0) ? (64'd1 << 29) : (64'd1 << 30);
			for (int k = 0; k < EXP_ROOTS; k++) begin
				if (x[EXP_ROOTS-1-k]) v = (v * root[k] + (64'd1 << 29)) >> 30;
			end
			t[i] = EXP_W'(v);
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

/* hdl/skdc_lane.sv */
// One channel lane: detector key and final scaling with saturation.
// Depends on skdc_pkg.
module skdc_lane import skdc_pkg::*; (
	input  logic                       clk,
	input  lane_ctl_t                  ctl,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [GM_W-1:0]            gm,
	output logic [KEY_W-1:0]           key,
	output logic signed [SAMPLE_W-1:0] result
);

	logic [SAMPLE_W-1:0]     mag;
	logic [2*SAMPLE_W-1:0]   sq;
	logic [33:0]             pwr_key;
	logic [32:0]             peak_key;
	logic [KEY_W-1:0]        key_d;
	logic [SAMPLE_W+GM_W-1:0] prod;
	logic [28:0]             r;
	logic [SAMPLE_W-1:0]     res_d;
	logic [KEY_W-1:0]        key_q;
	logic [SAMPLE_W-1:0]     result_q;

	always_comb begin
		mag      = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
		sq       = {24'd0, mag} * {24'd0, mag};
		pwr_key  = 34'((sq + 48'd8192) >> 14);
		peak_key = {mag, 9'd0};
		if (ctl.pwr) key_d = (pwr_key[33:32] != 2'd0) ? '1 : pwr_key[31:0];
		else         key_d = peak_key[32] ? '1 : peak_key[31:0];
		prod = {31'd0, mag} * {24'd0, gm};
		r    = 29'((prod + 55'd33554432) >> 26);
		if (sample[SAMPLE_W-1]) res_d = (r > 29'd8388608) ? 24'h800000 : (~r[23:0] + 1'b1);
		else                    res_d = (r > 29'd8388607) ? 24'h7FFFFF : r[23:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.key_en) key_q <= key_d;
		if (ctl.out_en) result_q <= res_d;
	end

	assign key    = key_q;
	assign result = result_q;

endmodule

/* hdl/skdc_div.sv */
// Restoring divider, one quotient bit per cycle, for the soft-knee reduction.
// Depends on skdc_pkg.
module skdc_div import skdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic              done,
	output logic [QUOT_W-1:0] quot
);

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsh_q;
	logic [QUOT_W-1:0] quot_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QUOT_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'({den, 13'd0});
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) rem_q <= rem_q - dsh_q;
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* hdl/soft_knee_dynamics_compressor_core.sv */
// Top level of the soft-knee feed-forward compressor: registers, sequencer,
// shared multiplier and level/gain math. Depends on skdc_pkg, skdc_lane, skdc_div.
//
// Channel   Handshake             Payload
// in        in_valid / in_stall   sample_ch0, sample_ch1
// out       out_valid / out_stall out_ch0, out_ch1, gain_linear
// cfg       cfg_we                cfg_index, cfg_data
//
// One frame is processed at a time; the input stalls from the transfer until the
// result is written. A silent envelope skips the normalisation and log steps, and
// only a level inside the knee with a negative slope uses the 14-step divider of
// the knee curve; the other steps pass through the one shared 32x32 multiplier.
// Reset clears the sequencer, the output valid flag, the envelope and loads the
// register defaults. A stalled result holds in the output registers while the
// next frame is already taken and worked on; only the final write waits.
module soft_knee_dynamics_compressor_core import skdc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] sample_ch0,
	input  logic signed [SAMPLE_W-1:0] sample_ch1,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_ch0,
	output logic signed [SAMPLE_W-1:0] out_ch1,
	output logic [GAIN_W-1:0]          gain_linear,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data
);

	localparam int LPOS_W = 31 + LOG_IDX_W;
	localparam int EPOS_W = 16 + EXP_IDX_W;

	// Sequencer codes.
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_KEY   = 5'd1;
	localparam logic [4:0] S_MERGE = 5'd2;
	localparam logic [4:0] S_ENV1  = 5'd3;
	localparam logic [4:0] S_ENV2  = 5'd4;
	localparam logic [4:0] S_ENV3  = 5'd5;
	localparam logic [4:0] S_NORM  = 5'd6;
	localparam logic [4:0] S_LOG0  = 5'd7;
	localparam logic [4:0] S_LOG1  = 5'd8;
	localparam logic [4:0] S_LOG2  = 5'd9;
	localparam logic [4:0] S_LOG3  = 5'd10;
	localparam logic [4:0] S_LOG4  = 5'd11;
	localparam logic [4:0] S_RED0  = 5'd12;
	localparam logic [4:0] S_RED1  = 5'd13;
	localparam logic [4:0] S_RED2  = 5'd14;
	localparam logic [4:0] S_RED3  = 5'd15;
	localparam logic [4:0] S_RED4  = 5'd16;
	localparam logic [4:0] S_DIV   = 5'd17;
	localparam logic [4:0] S_GAIN0 = 5'd18;
	localparam logic [4:0] S_GAIN1 = 5'd19;
	localparam logic [4:0] S_GAIN2 = 5'd20;
	localparam logic [4:0] S_GAIN3 = 5'd21;
	localparam logic [4:0] S_GAIN4 = 5'd22;
	localparam logic [4:0] S_GAIN5 = 5'd23;
	localparam logic [4:0] S_GAIN6 = 5'd24;
	localparam logic [4:0] S_OUT   = 5'd25;

	// Configuration registers.
	logic [15:0]         thr_q;
	logic [15:0]         slope_q;
	logic [13:0]         knee_q;
	logic [COEFF_W-1:0]  att_q;
	logic [COEFF_W-1:0]  rel_q;
	logic [MAKEUP_W-1:0] makeup_q;
	logic                rms_q;

	// Sequencer and datapath registers.
	logic [4:0]                 state_q;
	logic                       out_valid_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [SAMPLE_W-1:0] sample_q [CHANNELS];
	logic [KEY_W-1:0]           key_q;
	logic [COEFF_W-1:0]         c_q;
	logic [KEY_W-1:0]           env_q;
	logic [63:0]                p_q;
	logic [63:0]                acc_q;
	logic [KEY_W-1:0]           norm_q;
	logic [4:0]                 sh_q;
	logic [2:0]                 cnt_q;
	logic [LOG_W-1:0]           ta_q;
	logic [LOG_W-1:0]           tb_q;
	logic [30:0]                lrem_q;
	logic [21:0]                neg_q;
	logic signed [17:0]         lvl_q;
	logic signed [17:0]         over_q;
	logic [15:0]                m_q;
	logic [21:0]                e_q;
	logic [EXP_W-1:0]           ea_q;
	logic [EXP_W-1:0]           eb_q;
	logic [15:0]                erem_q;
	logic [5:0]                 n_q;
	logic [GAIN_W-1:0]          g_q;
	logic [GM_W-1:0]            gm_q;

	// Combinational helpers.
	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic                in_xfer;
	logic                out_free;
	logic [KEY_W-1:0]    key_max;
	logic [KEY_W-1:0]    lane_key [CHANNELS];
	logic signed [SAMPLE_W-1:0] lane_out [CHANNELS];
	lane_ctl_t           lane_ctl;
	logic [63:0]         env_sum;
	logic [KEY_W-1:0]    env_new;
	logic [4:0]          amt;
	logic [KEY_W-1:0]    top_mask;
	logic [LPOS_W-1:0]   lpos;
	logic [LOG_IDX_W-1:0] lidx;
	logic [17:0]         lval;
	logic signed [18:0]  twice;
	logic signed [18:0]  w19;
	logic [15:0]         sm;
	logic                knee_hit;
	logic                below;
	logic [14:0]         t2;
	logic [EPOS_W-1:0]   epos;
	logic [EXP_IDX_W-1:0] eidx;
	logic [EXP_W-1:0]    v;
	logic [6:0]          vshift;
	logic [31:0]         vs;
	logic [GAIN_W-1:0]   g_d;
	logic                div_start;
	logic                div_done;
	logic [QUOT_W-1:0]   div_quot;
	logic [NUM_W-1:0]    div_num;
	logic [DEN_W-1:0]    div_den;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	// The output registers may take a new result once the old one is gone.
	assign out_free = !out_valid_q || !out_stall;

	assign lane_ctl.key_en = state_q == S_KEY;
	assign lane_ctl.out_en = (state_q == S_OUT) && out_free;
	assign lane_ctl.pwr    = rms_q;

	for (genvar ln = 0; ln < CHANNELS; ln++) begin : g_lane
		skdc_lane u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.sample (sample_q[ln]),
			.gm     (gm_q),
			.key    (lane_key[ln]),
			.result (lane_out[ln])
		);
	end

	// Merge stage: the frame key is the largest lane key.
	always_comb begin
		key_max = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (lane_key[i] > key_max) key_max = lane_key[i];
		end
	end

	skdc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign div_start = state_q == S_RED4;
	assign div_num   = NUM_W'(p_q) + NUM_W'({knee_q, 17'd0});
	assign div_den   = DEN_W'({knee_q, 18'd0});

	always_comb begin
		// Envelope update: c*env + (1-c)*key, rounded.
		env_sum  = acc_q + p_q + 64'd8388608;
		env_new  = KEY_W'(env_sum >> 24);
		// Leading-one search, halving the step each cycle.
		amt      = 5'd16 >> cnt_q;
		top_mask = ~(32'hFFFF_FFFF >> amt);
		// Log table address and interpolation fraction.
		lpos     = LPOS_W'(norm_q[30:0]) * LPOS_W'(LOG_TABLE_DEPTH);
		lidx     = lpos[LPOS_W-1:31];
		lval     = 18'(ta_q) + 18'(p_q[47:31]);
		// Gain computer decisions.
		twice    = {over_q, 1'b0};
		w19      = {5'd0, knee_q};
		sm       = ~slope_q + 1'b1;
		knee_hit = (knee_q != 14'd0) && (twice > -w19) && (twice < w19);
		below    = twice <= -w19;
		t2       = 15'(twice + w19);
		// Exp table address and interpolation fraction.
		epos     = EPOS_W'(e_q[15:0]) * EPOS_W'(EXP_TABLE_DEPTH);
		eidx     = epos[EPOS_W-1:16];
		// Rounded shift by 16 + n, done as a shift by 15 + n and a half-step.
		v        = ea_q - EXP_W'(p_q >> 16);
		vshift   = 7'(n_q) + 7'd15;
		vs       = 32'({1'b0, v} >> vshift);
		g_d      = (n_q > 6'd30) ? '0 : GAIN_W'((vs + 32'd1) >> 1);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_ENV1: begin
				mul_a = 32'(c_q);
				mul_b = env_q;
			end
			S_ENV2: begin
				mul_a = 32'(25'h100_0000 - 25'(c_q));
				mul_b = key_q;
			end
			S_LOG1: begin
				mul_a = 32'(tb_q - ta_q);
				mul_b = {1'b0, lrem_q};
			end
			S_LOG3: begin
				mul_a = 32'(neg_q);
				mul_b = rms_q ? 32'(DB_PER_OCT_RMS) : 32'(DB_PER_OCT_PEAK);
			end
			S_RED1: begin
				if (knee_hit) begin
					mul_a = 32'(t2);
					mul_b = 32'(t2);
				end else begin
					mul_a = 32'(sm);
					mul_b = 32'(over_q[16:0]);
				end
			end
			S_RED3: begin
				mul_a = 32'(sm);
				mul_b = p_q[31:0];
			end
			S_GAIN0: begin
				mul_a = 32'(m_q);
				mul_b = 32'(OCT_PER_DB);
			end
			S_GAIN3: begin
				mul_a = 32'(ea_q - eb_q);
				mul_b = 32'(erem_q);
			end
			S_GAIN5: begin
				mul_a = 32'(g_q);
				mul_b = 32'(makeup_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= {32'd0, mul_a} * {32'd0, mul_b};
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 16'hEC00;
			slope_q  <= 16'hA000;
			knee_q   <= 14'd1536;
			att_q    <= 24'd16742303;
			rel_q    <= 24'd16773721;
			makeup_q <= 16'd4096;
			rms_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q    <= cfg_data[15:0];
				REG_SLOPE:     slope_q  <= cfg_data[15:0];
				REG_KNEE:      knee_q   <= cfg_data[13:0];
				REG_ATTACK:    att_q    <= cfg_data[23:0];
				REG_RELEASE:   rel_q    <= cfg_data[23:0];
				REG_MAKEUP:    makeup_q <= cfg_data[15:0];
				REG_RMS_MODE:  rms_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, envelope and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			env_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:  if (in_xfer) state_q <= S_KEY;
				S_KEY:   state_q <= S_MERGE;
				S_MERGE: state_q <= S_ENV1;
				S_ENV1:  state_q <= S_ENV2;
				S_ENV2:  state_q <= S_ENV3;
				S_ENV3: begin
					env_q   <= env_new;
					cnt_q   <= '0;
					// A silent envelope goes straight to the level floor.
					state_q <= (env_new == '0) ? S_RED0 : S_NORM;
				end
				S_NORM: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 3'd4) state_q <= S_LOG0;
				end
				S_LOG0: state_q <= S_LOG1;
				S_LOG1: state_q <= S_LOG2;
				S_LOG2: state_q <= S_LOG3;
				S_LOG3: state_q <= S_LOG4;
				S_LOG4: state_q <= S_RED0;
				S_RED0: state_q <= S_RED1;
				S_RED1: begin
					if (slope_q[15] && knee_hit)    state_q <= S_RED3;
					else if (slope_q[15] && !below) state_q <= S_RED2;
					else                            state_q <= S_GAIN0;
				end
				S_RED2:  state_q <= S_GAIN0;
				S_RED3:  state_q <= S_RED4;
				S_RED4:  state_q <= S_DIV;
				S_DIV:   if (div_done) state_q <= S_GAIN0;
				S_GAIN0: state_q <= S_GAIN1;
				S_GAIN1: state_q <= S_GAIN2;
				S_GAIN2: state_q <= S_GAIN3;
				S_GAIN3: state_q <= S_GAIN4;
				S_GAIN4: state_q <= S_GAIN5;
				S_GAIN5: state_q <= S_GAIN6;
				S_GAIN6: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q[0] <= sample_ch0;
			sample_q[1] <= sample_ch1;
		end
		case (state_q)
			S_MERGE: begin
				key_q <= key_max;
				c_q   <= (key_max > env_q) ? att_q : rel_q;
			end
			S_ENV2: acc_q <= p_q;
			S_ENV3: begin
				norm_q <= env_new;
				sh_q   <= '0;
				lvl_q  <= LEVEL_FLOOR_DB;
			end
			S_NORM: begin
				if ((norm_q & top_mask) == '0) begin
					norm_q <= norm_q << amt;
					sh_q   <= sh_q + amt;
				end
			end
			S_LOG0: begin
				ta_q   <= LOG_TAB[lidx];
				tb_q   <= LOG_TAB[LOG_IDX_W'(lidx + 1'b1)];
				lrem_q <= lpos[30:0];
			end
			S_LOG2: neg_q <= 22'({6'(sh_q) + 6'd1, 16'd0}) - 22'(lval);
			S_LOG4: lvl_q <= 18'sd0 - $signed(18'((p_q + 64'd8388608) >> 24));
			S_RED0: over_q <= lvl_q - $signed({{2{thr_q[15]}}, thr_q});
			S_RED1: m_q <= '0;
			S_RED2: m_q <= 16'((p_q + 64'd16384) >> 15);
			S_DIV:  if (div_done) m_q <= 16'(div_quot);
			S_GAIN1: e_q <= 22'((p_q + 64'd32768) >> 16);
			S_GAIN2: begin
				ea_q   <= EXP_TAB[eidx];
				eb_q   <= EXP_TAB[EXP_IDX_W'(eidx + 1'b1)];
				erem_q <= epos[15:0];
				n_q    <= e_q[21:16];
			end
			S_GAIN4: g_q <= g_d;
			S_GAIN6: gm_q <= p_q[GM_W-1:0];
			S_OUT:   if (out_free) gain_q <= g_q;
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign out_ch0     = lane_out[0];
	assign out_ch1     = lane_out[1];
	assign gain_linear = gain_q;

`ifndef SYNTHESIS
	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside the output step");
	a_env_update: assert property (@(posedge clk) disable iff (!arst_n)
		(env_q != $past(env_q)) |-> $past(state_q == S_ENV3))
		else $error("envelope changed outside its update step");
	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (gain_q <= 15'd16384))
		else $error("gain above unity");
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == S_KEY))
		else $error("accepted frame did not start the sequence");
`endif

endmodule

/* bench/soft_knee_dynamics_compressor_core_test.sv */
// Self-checking bench for the soft-knee compressor core: builds its own log2/exp2
// tables, predicts every frame bit for bit and compares each output transfer.
// Depends on skdc_pkg and soft_knee_dynamics_compressor_core.
`timescale 1ns / 100ps

module soft_knee_dynamics_compressor_core_test;
	import skdc_pkg::*;

	typedef struct {
		logic signed [SAMPLE_W-1:0] ch0;
		logic signed [SAMPLE_W-1:0] ch1;
	} frame_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] ch0;
		logic signed [SAMPLE_W-1:0] ch1;
		logic [GAIN_W-1:0]          gain;
	} comp_out_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample_ch0 = '0;
	logic signed [SAMPLE_W-1:0] sample_ch1 = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] out_ch0;
	logic signed [SAMPLE_W-1:0] out_ch1;
	logic [GAIN_W-1:0]          gain_linear;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_W-1:0]           cfg_data = '0;

	soft_knee_dynamics_compressor_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample_ch0(sample_ch0), .sample_ch1(sample_ch1),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_ch0(out_ch0), .out_ch1(out_ch1), .gain_linear(gain_linear),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// A 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The bench keeps its own copy of the control registers and the envelope.
	logic signed [15:0] thr_db   = -16'sd5120;
	logic signed [15:0] slope_q  = -16'sd24576;
	logic [13:0]        knee_db  = 14'd1536;
	logic [23:0]        atk_c    = 24'd16742303;
	logic [23:0]        rel_c    = 24'd16773721;
	logic [15:0]        makeup_q = 16'd4096;
	logic               pwr_mode = 1'b0;
	bit [63:0]          env_q    = 64'd0;

	bit [63:0] log2_lut [0:LOG_TABLE_DEPTH];
	bit [63:0] pow2_lut [0:EXP_TABLE_DEPTH];

	frame_t    frames_to_send [$];
	comp_out_t expected_out [$];
	int        frames_queued = 0;
	int        frames_sent = 0;
	int        results_seen = 0;
	int        error_count = 0;
	bit        no_gaps = 1'b0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	int        phase_count = 0;

	function automatic bit [63:0] int_sqrt(input bit [63:0] x);
		bit [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// log2(1 + i/D) in Q0.16 by repeated squaring; 2^(-i/D) in Q1.30 from
	// products of repeated square roots of one half.
	task automatic fill_luts();
		bit [63:0] sq_root [0:EXP_ROOTS-1];
		bit [63:0] y, r, x, v;
		for (int i = 0; i <= LOG_TABLE_DEPTH; i++) begin
			y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_DEPTH);
			r = 0;
			for (int k = 0; k < 18; k++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r = r | 64'd1;
				end
			end
			log2_lut[i] = (r + 2) >> 2;
		end
		sq_root[0] = int_sqrt(64'd1 << 59);
		for (int k = 1; k < EXP_ROOTS; k++) sq_root[k] = int_sqrt(sq_root[k-1] << 30);
		for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
			x = ((64'(i) << EXP_ROOTS) + EXP_TABLE_DEPTH / 2) / EXP_TABLE_DEPTH;
			v = (x >> EXP_ROOTS) != 0 ? (64'd1 << 29) : (64'd1 << 30);
			for (int k = 0; k < EXP_ROOTS; k++)
				if (x[EXP_ROOTS-1-k]) v = (v * sq_root[k] + (64'd1 << 29)) >> 30;
			pow2_lut[i] = v;
		end
	endtask

	// Envelope level in Q8.8 dB; a zero envelope sits on the floor.
	function automatic longint env_to_db(input bit [63:0] e, input bit pwr);
		int        p;
		bit [63:0] fr, pos, idx, rem, l, neg, k;
		if (e == 0) return longint'(LEVEL_FLOOR_DB);
		p = 31;
		while (!e[p]) p--;
		fr  = ((e << (31 - p)) & 64'hFFFF_FFFF) - (64'd1 << 31);
		pos = fr * LOG_TABLE_DEPTH;
		idx = pos >> 31;
		rem = pos & 64'h7FFF_FFFF;
		l   = log2_lut[idx] + (((log2_lut[idx+1] - log2_lut[idx]) * rem) >> 31);
		neg = 64'(32 - p) * 65536 - l;
		k   = pwr ? 64'(DB_PER_OCT_RMS) : 64'(DB_PER_OCT_PEAK);
		return -longint'((neg * k + (64'd1 << 23)) >> 24);
	endfunction

	// Size of the gain cut in Q8.8 dB: quadratic inside the knee, linear above.
	function automatic bit [63:0] cut_db(input longint lvl);
		longint    over, s, w;
		bit [63:0] sm, t2, den;
		over = lvl - longint'(thr_db);
		s    = longint'(slope_q);
		w    = longint'(knee_db);
		if (s >= 0) return 0;
		sm = 64'(-s);
		if (w > 0 && 2 * over > -w && 2 * over < w) begin
			t2  = 64'(2 * over + w);
			den = 64'(w) << 18;
			return (sm * t2 * t2 + den / 2) / den;
		end
		if (2 * over <= -w) return 0;
		return (sm * 64'(over) + (64'd1 << 14)) >> 15;
	endfunction

	function automatic bit [63:0] cut_to_gain(input bit [63:0] m);
		bit [63:0] e, n, f, pos, idx, rem, v, sh;
		e   = (m * 64'(OCT_PER_DB) + (64'd1 << 15)) >> 16;
		n   = e >> 16;
		f   = e & 64'hFFFF;
		pos = f * EXP_TABLE_DEPTH;
		idx = pos >> 16;
		rem = pos & 64'hFFFF;
		v   = pow2_lut[idx] - (((pow2_lut[idx] - pow2_lut[idx+1]) * rem) >> 16);
		if (n > 30) return 0;
		sh = 16 + n;
		return (v + (64'd1 << (sh - 1))) >> sh;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] scale_sample(
			input logic signed [SAMPLE_W-1:0] s, input bit [63:0] g);
		longint    sv;
		bit [63:0] a, r;
		sv = longint'(s);
		a  = 64'(sv < 0 ? -sv : sv);
		r  = (a * g * 64'(makeup_q) + (64'd1 << 25)) >> 26;
		if (sv < 0) return (r > (64'd1 << 23)) ? -24'sd8388608 : -SAMPLE_W'(r);
		return (r > (64'd1 << 23) - 1) ? 24'sd8388607 : SAMPLE_W'(r);
	endfunction

	function automatic bit [63:0] detector_key(input logic signed [SAMPLE_W-1:0] s);
		longint    sv;
		bit [63:0] a, k;
		sv = longint'(s);
		a  = 64'(sv < 0 ? -sv : sv);
		k  = pwr_mode ? (a * a + (64'd1 << 13)) >> 14 : a << 9;
		return (k > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : k;
	endfunction

	// Advances the envelope by one frame and returns the processed frame.
	function automatic comp_out_t compress_frame(input frame_t f);
		comp_out_t res;
		bit [63:0] key, k1, c, g;
		key = detector_key(f.ch0);
		k1  = detector_key(f.ch1);
		if (k1 > key) key = k1;
		c     = (key > env_q) ? 64'(atk_c) : 64'(rel_c);
		env_q = (c * env_q + ((64'd1 << 24) - c) * key + (64'd1 << 23)) >> 24;
		g = cut_to_gain(cut_db(env_to_db(env_q, pwr_mode)));
		res.ch0  = scale_sample(f.ch0, g);
		res.ch1  = scale_sample(f.ch1, g);
		res.gain = GAIN_W'(g);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		error_count++;
		$display("ERROR t=%0t result %0d: %s got %0d, expected %0d",
			$time, results_seen, what, got, want);
	endtask

	// Driver: offers pending frames with a random gap before each one. A frame
	// held under in_stall keeps its payload until the transfer happens.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_out.push_back(compress_frame('{sample_ch0, sample_ch1}));
				frames_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (frames_to_send.size() > 0) begin
					frame_t f;
					f = frames_to_send.pop_front();
					in_valid   <= 1'b1;
					sample_ch0 <= f.ch0;
					sample_ch1 <= f.ch1;
					gap_left = no_gaps ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each output transfer against the oldest prediction and
	// draws a fresh stall length, spent while the next result is offered.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				comp_out_t want;
				if (expected_out.size() == 0) begin
					error_count++;
					$display("ERROR t=%0t output transfer with nothing predicted", $time);
				end else begin
					want = expected_out.pop_front();
					if (out_ch0 !== want.ch0) report_mismatch("out_ch0", out_ch0, want.ch0);
					if (out_ch1 !== want.ch1) report_mismatch("out_ch1", out_ch1, want.ch1);
					if (gain_linear !== want.gain)
						report_mismatch("gain_linear", gain_linear, want.gain);
				end
				results_seen++;
				stall_left = no_gaps ? 0 : $urandom_range(0, 5);
			end else if (stall_left > 0 && out_valid) begin
				stall_left--;
			end
			out_stall <= (stall_left > 0) || (hold_left > 0);
		end
	end

	// Long receiver hold-off, once, while the driver keeps offering frames, so
	// the core fills its output register and has to push back on its input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && frames_sent >= 60) begin
			hold_done <= 1'b1;
			hold_left <= 400;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_THRESHOLD: thr_db   = val[15:0];
			REG_SLOPE:     slope_q  = val[15:0];
			REG_KNEE:      knee_db  = val[13:0];
			REG_ATTACK:    atk_c    = val[23:0];
			REG_RELEASE:   rel_c    = val[23:0];
			REG_MAKEUP:    makeup_q = val[15:0];
			REG_RMS_MODE:  pwr_mode = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_frame(input int a, input int b);
		frames_to_send.push_back('{SAMPLE_W'(a), SAMPLE_W'(b)});
		frames_queued++;
	endtask

	// Waits until every queued frame has come back out of the core.
	task automatic drain();
		while (results_seen < frames_queued) @(posedge clk);
	endtask

	// Sample drawn according to the signal character of the current burst.
	function automatic int draw_sample(input int kind);
		int v;
		case (kind)
			0: v = $urandom;
			1: v = $signed($urandom) >>> $urandom_range(8, 31);
			2: v = ($urandom_range(0, 1) ? 8388607 : -8388608) - $urandom_range(0, 4095)
				* ($urandom_range(0, 1) ? 1 : -1);
			default: v = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) - 1 : 0;
		endcase
		return v;
	endfunction

	function automatic logic [23:0] draw_coeff();
		case ($urandom_range(0, 5))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			2: return 24'($urandom);
			default: return 24'(24'hFFFFFF - $urandom_range(0, 1 << $urandom_range(4, 18)));
		endcase
	endfunction

	task automatic random_settings();
		write_reg(REG_THRESHOLD, $urandom_range(0, 3) == 0 ?
			($urandom_range(0, 1) ? 24'd0 : 24'(-24576)) : 24'(-$urandom_range(0, 24576)));
		write_reg(REG_SLOPE, $urandom_range(0, 4) == 0 ?
			($urandom_range(0, 1) ? 24'd0 : 24'(-32768)) : 24'(-$urandom_range(0, 32768)));
		write_reg(REG_KNEE, $urandom_range(0, 3) == 0 ?
			($urandom_range(0, 1) ? 24'd0 : 24'd12288) : 24'($urandom_range(0, 12288)));
		write_reg(REG_ATTACK, draw_coeff());
		write_reg(REG_RELEASE, draw_coeff());
		write_reg(REG_MAKEUP, $urandom_range(0, 4) == 0 ?
			($urandom_range(0, 1) ? 24'd0 : 24'd65535) : 24'($urandom_range(1024, 20000)));
		write_reg(REG_RMS_MODE, 24'($urandom_range(0, 1)));
	endtask

	// Stimulus: directed corner frames under hand-picked settings, then random
	// settings with bursts of loud, quiet, silent and full-range frames.
	initial begin
		int kind, burst;
		fill_luts();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset, starting from a silent envelope.
		queue_frame(0, 0);
		queue_frame(1, -1);
		queue_frame(8388607, 0);
		queue_frame(-8388608, -8388608);
		queue_frame(0, 8388607);
		queue_frame(-1, 1);
		queue_frame(4096, -4096);
		drain();
		phase_count++;

		// Flat slope gives unity gain; full makeup drives the outputs into clipping.
		write_reg(REG_SLOPE, 24'd0);
		write_reg(REG_MAKEUP, 24'd65535);
		queue_frame(8388607, -8388608);
		queue_frame(100000, -100000);
		queue_frame(1, -1);
		queue_frame(0, 0);
		drain();
		phase_count++;

		// Infinite ratio, lowest threshold, hard knee, instant attack: deep cut
		// to zero gain for loud input.
		write_reg(REG_THRESHOLD, 24'(-24576));
		write_reg(REG_SLOPE, 24'(-32768));
		write_reg(REG_KNEE, 24'd0);
		write_reg(REG_ATTACK, 24'd0);
		write_reg(REG_RELEASE, 24'hFFFFFF);
		queue_frame(-8388608, 8388607);
		queue_frame(8388607, 8388607);
		queue_frame(3, -2);
		queue_frame(0, 0);
		drain();
		phase_count++;

		// Power detector on top of the envelope left by peak mode, widest knee.
		write_reg(REG_RMS_MODE, 24'd1);
		write_reg(REG_KNEE, 24'd12288);
		write_reg(REG_THRESHOLD, 24'd0);
		write_reg(REG_MAKEUP, 24'd4096);
		write_reg(REG_ATTACK, 24'd16742303);
		queue_frame(-8388608, 0);
		queue_frame(2000000, -3000000);
		queue_frame(0, 0);
		queue_frame(8388607, -8388608);
		drain();
		phase_count++;

		// Random part: ten settings of 133 frames each.
		for (int ph = 0; ph < 10; ph++) begin
			random_settings();
			no_gaps = (ph % 4 == 3);
			burst = 0;
			kind = 0;
			for (int n = 0; n < 133; n++) begin
				if (burst == 0) begin
					kind = $urandom_range(0, 3);
					burst = $urandom_range(1, 40);
				end
				burst--;
				queue_frame(draw_sample(kind), draw_sample(kind));
			end
			drain();
			phase_count++;
		end

		repeat (60) @(posedge clk);
		$display("Ran %0d frames over %0d register settings, peak and power detectors,",
			frames_queued, phase_count);
		$display("hard and soft knees, clipping and zero-gain corners; %0d mismatches.",
			error_count);
		if (error_count == 0 && expected_out.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("FAILURE");
		$finish;
	end

endmodule
